>>> rtl/incremental_bounding_sphere_grow_defines.svh
// Assertion macros shared by the incremental bounding sphere RTL.
`ifndef INCREMENTAL_BOUNDING_SPHERE_GROW_DEFINES_SVH
`define INCREMENTAL_BOUNDING_SPHERE_GROW_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IBSG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IBSG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ibsg_pkg.sv
// Package with widths, codes and controller/datapath types for the sphere grow block.
package ibsg_pkg;

  localparam int COORD_W    = 32;
  localparam int RAD_W      = 31;
  localparam int MAG_W      = COORD_W + 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int DEN_W      = ROOT_W + 1;
  localparam int Q_W        = COORD_W;
  localparam int LO_W       = 17;
  localparam int HI_W       = MAG_W - LO_W;
  localparam int PP_W       = MAG_W + LO_W;
  localparam int SQRT_ITERS = ROOT_W;
  localparam int DIV_ITERS  = Q_W;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd3;

  // Product slots of the shared multiplier.
  localparam logic [2:0] MUL_SQ_X  = 3'd0;
  localparam logic [2:0] MUL_SQ_Y  = 3'd1;
  localparam logic [2:0] MUL_SQ_Z  = 3'd2;
  localparam logic [2:0] MUL_RR    = 3'd3;
  localparam logic [2:0] MUL_GAP_X = 3'd4;
  localparam logic [2:0] MUL_GAP_Y = 3'd5;
  localparam logic [2:0] MUL_GAP_Z = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SQ_MUL, S_SQ_DRAIN, S_COMPARE, S_ROOT, S_GAP,
    S_GP_MUL, S_GP_DRAIN, S_DIV_INIT, S_DIVIDE, S_UPDATE, S_DONE
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       load;
    logic       mul_en;
    logic [2:0] mul_idx;
    logic       mul_half;
    logic       compare;
    logic       sqrt_step;
    logic       gap;
    logic       div_init;
    logic       div_step;
    logic       update;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic grow;
  } status_t;

endpackage

>>> rtl/ibsg_ctrl.sv
// Controller state machine sequencing the sphere grow datapath.
`include "incremental_bounding_sphere_grow_defines.svh"

module ibsg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ibsg_pkg::status_t sts,
  output ibsg_pkg::cmd_t   cmd
);
  import ibsg_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        cnt_next   = '0;
        state_next = S_SQ_MUL;
      end
      S_SQ_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_idx  = {1'b0, cnt[2:1]};
        cmd.mul_half = cnt[0];
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(7)) state_next = S_SQ_DRAIN;
      end
      S_SQ_DRAIN: state_next = S_COMPARE;
      S_COMPARE: begin
        cmd.compare = 1'b1;
        cnt_next    = '0;
        state_next  = S_ROOT;
      end
      S_ROOT: begin
        if (!sts.grow) begin
          state_next = S_DONE;
        end else begin
          cmd.sqrt_step = 1'b1;
          cnt_next      = cnt + 1'b1;
          if (cnt == CNT_W'(SQRT_ITERS - 1)) state_next = S_GAP;
        end
      end
      S_GAP: begin
        cmd.gap    = 1'b1;
        cnt_next   = '0;
        state_next = S_GP_MUL;
      end
      S_GP_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_idx  = MUL_GAP_X + {1'b0, cnt[2:1]};
        cmd.mul_half = cnt[0];
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(5)) state_next = S_GP_DRAIN;
      end
      S_GP_DRAIN: state_next = S_DIV_INIT;
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_ITERS - 1)) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `IBSG_ASSERT_NXT(a_accept_load, clk, rst, in_valid && in_ready, state == S_LOAD, "accept must go to load")
  `IBSG_ASSERT_IMP(a_out_free, clk, rst, cmd.out_load, !out_valid || out_ready, "output register overwritten")
  `IBSG_ASSERT_IMP(a_gap_grow, clk, rst, state == S_GAP, sts.grow, "gap state without growth")
  `IBSG_ASSERT_IMP(a_root_cnt, clk, rst, state == S_ROOT, cnt < CNT_W'(SQRT_ITERS), "root counter overrun")

endmodule

>>> rtl/ibsg_dpath.sv
// Datapath: sphere state, shared split multiplier, square root and three divider lanes.
module ibsg_dpath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ibsg_pkg::cmd_t                         cmd,
  output ibsg_pkg::status_t                      sts,
  input  logic                                   cfg_we,
  input  logic [ibsg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ibsg_pkg::COORD_W-1:0]           cfg_data,
  input  logic                                   start_req,
  input  logic signed [ibsg_pkg::COORD_W-1:0]    point_x,
  input  logic signed [ibsg_pkg::COORD_W-1:0]    point_y,
  input  logic signed [ibsg_pkg::COORD_W-1:0]    point_z,
  output logic signed [ibsg_pkg::COORD_W-1:0]    center_x,
  output logic signed [ibsg_pkg::COORD_W-1:0]    center_y,
  output logic signed [ibsg_pkg::COORD_W-1:0]    center_z,
  output logic [ibsg_pkg::RAD_W-1:0]             radius,
  output logic                                   grew,
  output logic                                   was_inside
);
  import ibsg_pkg::*;

  logic [COORD_W-1:0] init_c [3];
  logic [RAD_W-1:0]   init_r;
  logic [COORD_W-1:0] pt [3];
  logic               start;
  logic [COORD_W-1:0] ctr [3];
  logic [RAD_W-1:0]   rad;
  logic [MAG_W-1:0]   mag [3];
  logic               neg [3];
  logic [SQ_W-1:0]    acc, r2;
  logic [SQ_W-1:0]    prod [3];
  logic               grow_f, inside_f;
  logic [PP_W-1:0]    pp;
  logic [2:0]         pp_idx;
  logic               pp_half, pp_vld;
  logic [SQ_W-1:0]    rad_sh;
  logic [MAG_W+1:0]   sq_rem;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W-1:0]  gap;
  logic [DEN_W-1:0]   den;
  logic [RAD_W-1:0]   new_r;
  logic [DEN_W-1:0]   drem [3];
  logic [Q_W-1:0]     dq [3];

  logic [COORD_W-1:0] eff_c [3];
  logic [MAG_W-1:0]   diff [3];
  logic [MAG_W-1:0]   mul_a, mul_b;
  logic [LO_W-1:0]    mul_bp;
  logic [SQ_W-1:0]    pp_add;
  logic [MAG_W+3:0]   sq_t, sq_trial;
  logic [DEN_W:0]     d_t [3];
  logic [DEN_W-1:0]   r_plus_d;

  assign sts.grow = grow_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) init_c[i] <= '0;
      init_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X: init_c[0] <= cfg_data;
        CFG_CENTER_Y: init_c[1] <= cfg_data;
        CFG_CENTER_Z: init_c[2] <= cfg_data;
        CFG_RADIUS:   init_r    <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eff_c[i] = start ? init_c[i] : ctr[i];
      diff[i]  = {pt[i][COORD_W-1], pt[i]} - {eff_c[i][COORD_W-1], eff_c[i]};
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.mul_idx)
      MUL_SQ_X:  begin mul_a = mag[0]; mul_b = mag[0]; end
      MUL_SQ_Y:  begin mul_a = mag[1]; mul_b = mag[1]; end
      MUL_SQ_Z:  begin mul_a = mag[2]; mul_b = mag[2]; end
      MUL_RR:    begin mul_a = MAG_W'(rad); mul_b = MAG_W'(rad); end
      MUL_GAP_X: begin mul_a = mag[0]; mul_b = gap; end
      MUL_GAP_Y: begin mul_a = mag[1]; mul_b = gap; end
      MUL_GAP_Z: begin mul_a = mag[2]; mul_b = gap; end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
    mul_bp = cmd.mul_half ? LO_W'(mul_b[MAG_W-1:LO_W]) : mul_b[LO_W-1:0];
    pp_add = pp_half ? (SQ_W'(pp) << LO_W) : SQ_W'(pp);
  end

  always_comb begin
    sq_t     = {sq_rem, rad_sh[SQ_W-1:SQ_W-2]};
    sq_trial = (MAG_W+4)'({root, 2'b01});
    r_plus_d = DEN_W'(rad) + DEN_W'(root);
    for (int i = 0; i < 3; i++) d_t[i] = {drem[i], dq[i][Q_W-1]};
  end

  // The sphere itself clears on reset, reloads on a start and moves on growth.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) ctr[i] <= '0;
      rad <= '0;
    end else if (cmd.load) begin
      for (int i = 0; i < 3; i++) ctr[i] <= eff_c[i];
      if (start) rad <= init_r;
    end else if (cmd.update) begin
      for (int i = 0; i < 3; i++) ctr[i] <= neg[i] ? ctr[i] - dq[i] : ctr[i] + dq[i];
      rad <= new_r;
    end
  end

  always_ff @(posedge clk) begin
    pp_vld <= cmd.mul_en;
    if (cmd.mul_en) begin
      pp      <= PP_W'(mul_a) * PP_W'(mul_bp);
      pp_idx  <= cmd.mul_idx;
      pp_half <= cmd.mul_half;
    end

    if (cmd.capture) begin
      pt[0] <= point_x;
      pt[1] <= point_y;
      pt[2] <= point_z;
      start <= start_req;
    end

    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        neg[i] <= diff[i][MAG_W-1];
        mag[i] <= diff[i][MAG_W-1] ? (MAG_W'(0) - diff[i]) : diff[i];
      end
      acc <= '0;
      r2  <= '0;
    end

    if (pp_vld) begin
      case (pp_idx)
        MUL_SQ_X, MUL_SQ_Y, MUL_SQ_Z: acc <= acc + pp_add;
        MUL_RR:    r2      <= r2 + pp_add;
        MUL_GAP_X: prod[0] <= prod[0] + pp_add;
        MUL_GAP_Y: prod[1] <= prod[1] + pp_add;
        MUL_GAP_Z: prod[2] <= prod[2] + pp_add;
        default: ;
      endcase
    end

    if (cmd.compare) begin
      grow_f   <= acc > r2;
      inside_f <= acc < r2;
      rad_sh   <= acc;
      sq_rem   <= '0;
      root     <= '0;
    end

    if (cmd.sqrt_step) begin
      rad_sh <= rad_sh << 2;
      if (sq_t >= sq_trial) begin
        sq_rem <= (MAG_W+2)'(sq_t - sq_trial);
        root   <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem <= (MAG_W+2)'(sq_t);
        root   <= {root[ROOT_W-2:0], 1'b0};
      end
    end

    if (cmd.gap) begin
      gap   <= root - ROOT_W'(rad);
      den   <= {root, 1'b0};
      new_r <= (r_plus_d[DEN_W-1:RAD_W+1] != '0) ? {RAD_W{1'b1}} : r_plus_d[RAD_W:1];
      for (int i = 0; i < 3; i++) prod[i] <= '0;
    end

    if (cmd.div_init) begin
      for (int i = 0; i < 3; i++) begin
        drem[i] <= prod[i][SQ_W-1:Q_W];
        dq[i]   <= prod[i][Q_W-1:0];
      end
    end

    if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        if (d_t[i] >= {1'b0, den}) begin
          drem[i] <= DEN_W'(d_t[i] - {1'b0, den});
          dq[i]   <= {dq[i][Q_W-2:0], 1'b1};
        end else begin
          drem[i] <= DEN_W'(d_t[i]);
          dq[i]   <= {dq[i][Q_W-2:0], 1'b0};
        end
      end
    end

    if (cmd.out_load) begin
      center_x   <= ctr[0];
      center_y   <= ctr[1];
      center_z   <= ctr[2];
      radius     <= rad;
      grew       <= grow_f;
      was_inside <= inside_f;
    end
  end

endmodule

>>> rtl/incremental_bounding_sphere_grow.sv
// Top level of the incremental bounding sphere grow block.
// Every point takes split products on the shared multiplier and a compare; a point that lies inside
// or on the sphere then goes to the result, while a point that grows it runs the 33-step square root
// and the 32-step divider lanes, for seven split products on the shared multiplier in all.
// A new point is taken only after the previous result has gone into the output register, where it parks.
// Reset (rst, synchronous, active high) clears the controller; sphere and config start at zero.
module incremental_bounding_sphere_grow (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ibsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ibsg_pkg::COORD_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                start_req,
  input  logic signed [ibsg_pkg::COORD_W-1:0] point_x,
  input  logic signed [ibsg_pkg::COORD_W-1:0] point_y,
  input  logic signed [ibsg_pkg::COORD_W-1:0] point_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ibsg_pkg::COORD_W-1:0] center_x,
  output logic signed [ibsg_pkg::COORD_W-1:0] center_y,
  output logic signed [ibsg_pkg::COORD_W-1:0] center_z,
  output logic [ibsg_pkg::RAD_W-1:0]          radius,
  output logic                                grew,
  output logic                                was_inside
);
  import ibsg_pkg::*;

  // The controller steps the datapath through reload, squared distance, compare,
  // square root, offset products, division and center update. The finished
  // transaction sits in the output register, so a new point can be accepted
  // while the previous result waits for the consumer.
  cmd_t    cmd;
  status_t sts;

  // Reset clears the configuration registers and the sphere, so a first point
  // without start_req is measured against a zero-radius sphere at the origin.
  ibsg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ibsg_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start_req  (start_req),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .center_x   (center_x),
    .center_y   (center_y),
    .center_z   (center_z),
    .radius     (radius),
    .grew       (grew),
    .was_inside (was_inside)
  );

endmodule

>>> bench/incremental_bounding_sphere_grow_tb.sv
// Self-checking testbench for the incremental bounding sphere grow block.
`timescale 1ns / 100ps

module incremental_bounding_sphere_grow_tb;
  import ibsg_pkg::*;

  // One sphere update as seen on the result channel.
  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [RAD_W-1:0]          r;
    logic                      grew;
    logic                      was_in;
  } sphere_t;

  // A directed point; the sphere is typed in only where it is obvious.
  typedef struct {
    logic                      start;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      typed;
    sphere_t                   sph;
  } point_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [COORD_W-1:0]        cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      start_req = 1'b0;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic signed [COORD_W-1:0] point_z = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic [RAD_W-1:0]          radius;
  logic                      grew;
  logic                      was_inside;

  incremental_bounding_sphere_grow u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_req(start_req), .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .radius(radius), .grew(grew), .was_inside(was_inside)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copies of the init registers and of the running sphere.
  logic [COORD_W-1:0] init_c[3];
  logic [RAD_W-1:0]   init_r;
  logic [COORD_W-1:0] cur_c[3];
  logic [RAD_W-1:0]   cur_r;

  sphere_t    pending_spheres[$];
  sphere_t    typed_spheres[$];
  logic       typed_flags[$];
  int         errors = 0;
  int         burst_left = 0;
  bit         hold_req = 1'b0;
  point_row_t rows[11];

  // Ritter grow step on the shadow sphere. Offsets are exact in 64 bits and squares in 128 bits,
  // the root is floored, and every center step truncates toward zero.
  function automatic sphere_t grow_sphere(input logic start, input logic [COORD_W-1:0] p[3]);
    logic [63:0]  diff, d, gap, nr, cand;
    logic [63:0]  mag[3];
    logic         neg[3];
    logic [127:0] sq, r2, quo;
    sphere_t      res;
    if (start) begin
      cur_c = init_c;
      cur_r = init_r;
    end
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      diff = {{32{p[i][COORD_W-1]}}, p[i]} - {{32{cur_c[i][COORD_W-1]}}, cur_c[i]};
      neg[i] = diff[63];
      mag[i] = neg[i] ? -diff : diff;
      sq += {64'd0, mag[i]} * {64'd0, mag[i]};
    end
    r2 = {97'd0, cur_r} * {97'd0, cur_r};
    res.was_in = sq < r2;
    res.grew = sq > r2;
    if (res.grew) begin
      d = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = d | (64'd1 << b);
        if ({64'd0, cand} * {64'd0, cand} <= sq) d = cand;
      end
      gap = d - {33'd0, cur_r};
      nr = ({33'd0, cur_r} + d) >> 1;
      for (int i = 0; i < 3; i++) begin
        quo = ({64'd0, mag[i]} * {64'd0, gap}) / ({64'd0, d} << 1);
        cur_c[i] = neg[i] ? cur_c[i] - quo[COORD_W-1:0] : cur_c[i] + quo[COORD_W-1:0];
      end
      // The center moves by the full step even when the radius clips.
      cur_r = (nr > 64'h7fff_ffff) ? 31'h7fff_ffff : nr[RAD_W-1:0];
    end
    res.cx = cur_c[0];
    res.cy = cur_c[1];
    res.cz = cur_c[2];
    res.r = cur_r;
    return res;
  endfunction

  // Register writes and accepted points are mirrored at the same edge the block sees them.
  always @(posedge clk) begin
    logic [COORD_W-1:0] p[3];
    sphere_t            sph;
    if (!rst && cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: init_c[0] = cfg_data;
        CFG_CENTER_Y: init_c[1] = cfg_data;
        CFG_CENTER_Z: init_c[2] = cfg_data;
        CFG_RADIUS:   init_r = cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
    if (!rst && in_valid && in_ready) begin
      p[0] = point_x;
      p[1] = point_y;
      p[2] = point_z;
      sph = grow_sphere(start_req, p);
      // A typed row replaces the predicted sphere, so the predictor itself is checked.
      if (typed_flags.size() > 0 && typed_flags.pop_front())
        sph = typed_spheres.pop_front();
      pending_spheres.push_back(sph);
    end
  end

  function automatic void check_field(input string name, input logic [COORD_W-1:0] exp_v,
                                      input logic [COORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  // Every result transaction is matched against the oldest expected sphere.
  always @(posedge clk) begin
    sphere_t sph;
    if (!rst && out_valid && out_ready) begin
      if (pending_spheres.size() == 0) begin
        errors++;
        $display("%0t: result transaction with nothing expected, actual r=%h", $time, radius);
      end else begin
        sph = pending_spheres.pop_front();
        check_field("center_x", sph.cx, center_x);
        check_field("center_y", sph.cy, center_y);
        check_field("center_z", sph.cz, center_z);
        check_field("radius", {1'b0, sph.r}, {1'b0, radius});
        check_field("grew", {31'd0, sph.grew}, {31'd0, grew});
        check_field("was_inside", {31'd0, sph.was_in}, {31'd0, was_inside});
      end
    end
  end

  // Receiver: long free-running stretches alternate with random stalls, and on request
  // it holds out_ready low while the sender keeps offering points.
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (cyc[9:8] == 2'd0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Offers one point and returns at the edge where it was taken. Bursts of random
  // length are separated by random gaps.
  task automatic send_point(input logic st, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    start_req <= st;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Waits for every expected sphere, then past the longest latency.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_spheres.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_init(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                           input logic [COORD_W-1:0] cz, input logic [COORD_W-1:0] r);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CENTER_X;
    cfg_data <= cx;
    @(posedge clk);
    cfg_index <= CFG_CENTER_Y;
    cfg_data <= cy;
    @(posedge clk);
    cfg_index <= CFG_CENTER_Z;
    cfg_data <= cz;
    @(posedge clk);
    cfg_index <= CFG_RADIUS;
    cfg_data <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random point: mostly near the current sphere so inside, equal-ish and grow cases
  // all occur, with some full-range coordinates and occasional reloads.
  task automatic send_random;
    logic [COORD_W-1:0] p[3];
    logic               st;
    int                 kind;
    int                 span;
    kind = $urandom_range(0, 9);
    st = ($urandom_range(0, 19) == 0);
    span = $urandom_range(4, 30);
    for (int i = 0; i < 3; i++) begin
      if (kind < 2)
        p[i] = $urandom;
      else
        p[i] = cur_c[i] + ($urandom & ((32'd1 << span) - 1)) - (32'd1 << (span - 1));
    end
    send_point(st, p[0], p[1], p[2]);
  endtask

  initial begin
    logic [COORD_W-1:0] cx, cy, cz, r;
    // After reset the registers are zero, so the directed rows start from an empty sphere.
    rows[0]  = '{1'b1, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}};
    rows[1]  = '{1'b0, 32'h10000, 32'h0, 32'h0, 1'b1,
                 '{32'h8000, 32'h0, 32'h0, 31'h8000, 1'b1, 1'b0}};
    // Point exactly on the sphere: neither grown nor inside.
    rows[2]  = '{1'b0, 32'h10000, 32'h0, 32'h0, 1'b1,
                 '{32'h8000, 32'h0, 32'h0, 31'h8000, 1'b0, 1'b0}};
    rows[3]  = '{1'b0, 32'h8000, 32'h0, 32'h0, 1'b1,
                 '{32'h8000, 32'h0, 32'h0, 31'h8000, 1'b0, 1'b1}};
    rows[4]  = '{1'b0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, '{default: '0}};
    // Far corner: the radius saturates while the center still moves.
    rows[5]  = '{1'b0, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, '{default: '0}};
    rows[6]  = '{1'b1, 32'h80000000, 32'h7fffffff, 32'h0, 1'b0, '{default: '0}};
    rows[7]  = '{1'b0, 32'h0, 32'hffffffff, 32'h1, 1'b0, '{default: '0}};
    rows[8]  = '{1'b1, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 32'h0, 31'h0, 1'b0, 1'b0}};
    // Tiny offset: grows, but the floored root keeps the radius at zero.
    rows[9]  = '{1'b0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, '{default: '0}};
    rows[10] = '{1'b0, 32'h55555555, 32'haaaaaaaa, 32'h12345678, 1'b0, '{default: '0}};

    init_c = '{default: '0};
    cur_c = '{default: '0};
    init_r = '0;
    cur_r = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      typed_flags.push_back(rows[i].typed);
      if (rows[i].typed) typed_spheres.push_back(rows[i].sph);
      send_point(rows[i].start, rows[i].x, rows[i].y, rows[i].z);
    end

    for (int phase = 0; phase < 5; phase++) begin
      // The sender pauses here until every expected sphere has come back.
      drain();
      case (phase)
        0: begin cx = 0; cy = 0; cz = 0; r = 32'h10000; end
        1: begin cx = 32'h7fffffff; cy = 32'h80000000; cz = 32'h7fffffff; r = 32'h7fffffff; end
        2: begin cx = 32'h80000000; cy = 32'h80000000; cz = 32'h80000000; r = 0; end
        default: begin
          cx = $urandom_range(0, 32'hfffff) - 32'h80000;
          cy = $urandom_range(0, 32'hfffff) - 32'h80000;
          cz = $urandom_range(0, 32'hfffff) - 32'h80000;
          r = $urandom_range(0, 32'h7ffff);
        end
      endcase
      load_init(cx, cy, cz, r);
      if (phase == 1) hold_req = 1'b1;
      send_point(1'b1, $urandom, $urandom, $urandom);
      repeat (300) send_random();
    end

    drain();
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ibsg_pkg.sv
rtl/ibsg_ctrl.sv
rtl/ibsg_dpath.sv
rtl/incremental_bounding_sphere_grow.sv
bench/incremental_bounding_sphere_grow_tb.sv
